// ----- hdl/spfpu_pkg.sv -----
// Shared types, operation codes and constants for the single-precision FPU.
`default_nettype none
package spfpu_pkg;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_NEG   = 4'd4;
    localparam logic [3:0] OP_S2F   = 4'd5;
    localparam logic [3:0] OP_U2F   = 4'd6;
    localparam logic [3:0] OP_F2S32 = 4'd7;
    localparam logic [3:0] OP_F2U32 = 4'd8;
    localparam logic [3:0] OP_F2S64 = 4'd9;
    localparam logic [3:0] OP_CMP   = 4'd10;
    localparam logic [3:0] OP_UNORD = 4'd11;

    localparam logic [31:0] ABS_MASK = 32'h7FFF_FFFF;
    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [31:0] EXP_MASK = 32'h7F80_0000;
    localparam logic [31:0] MAN_MASK = 32'h007F_FFFF;
    localparam logic [10:0] EXP_BIAS = 11'd127;
    localparam logic [63:0] INT32_TOP = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] INT32_LOW = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] UINT32_TOP = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] INT64_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [31:0] F_INT32_LOW = 32'hCF00_0000;
    localparam logic [31:0] F_INT64_MIN = 32'hDF00_0000;

    localparam logic [1:0] ORD_LT = 2'b11;
    localparam logic [1:0] ORD_EQ = 2'b00;
    localparam logic [1:0] ORD_GT = 2'b01;

    localparam int QUO_W      = 28;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = QUO_W / DIV_BITS;
    localparam int PRE_DLY    = DIV_STAGES - 3;

    // value ahead of rounding, or a finished word when rnd is low
    typedef struct packed {
        logic        rnd;
        logic        is_div;
        logic        sign;
        logic [10:0] expo;
        logic [26:0] sig;
        logic [63:0] bits;
        logic [1:0]  order;
        logic        unord;
        logic        flag;
    } t_pre;

    typedef struct packed {
        logic             sign;
        logic [10:0]      expo;
        logic [23:0]      mb;
        logic [24:0]      rem;
        logic [QUO_W-1:0] quo;
    } t_div;

    function automatic logic [4:0] lzc32(input logic [31:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                n = 5'(31 - i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/spfpu_in_if.sv -----
// Input channel: operation code and two operands with valid/ready.
`default_nettype none
interface spfpu_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    modport source (output valid, action, operand_a, operand_b, input ready);
    modport sink (input valid, action, operand_a, operand_b, output ready);
endinterface
`default_nettype wire

// ----- hdl/spfpu_out_if.sv -----
// Output channel: result word with valid/ready.
`default_nettype none
interface spfpu_out_if;
    logic              valid;
    logic              ready;
    logic [63:0]       result_bits;
    logic signed [1:0] order;
    logic              unordered;
    logic              range_flag;
    modport source (output valid, result_bits, order, unordered, range_flag, input ready);
    modport sink (input valid, result_bits, order, unordered, range_flag, output ready);
endinterface
`default_nettype wire

// ----- hdl/single_precision_fpu_core.sv -----
// Top level of the pipelined single-precision FPU.
// Accepts one word per cycle unless the output stalls, and every result takes the same time to pass,
// whatever the operation; that time is set by the 14-stage radix-4 divider, which
// all other operations wait alongside so results leave in order. When the output is
// stalled the whole pipeline holds. Zero and subnormal inputs read as zero, rounding
// is to nearest even, and exponent overflow or underflow gives signed infinity or
// signed zero with range_flag set.
`default_nettype none
module single_precision_fpu_core
    import spfpu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    spfpu_in_if.sink    i_in,
    spfpu_out_if.source o_out
);

    logic en;
    logic front_valid, div_valid, out_valid;
    t_pre front_pre, div_pre;
    t_div front_div;
    logic [1:0] out_order;

    assign en         = !out_valid || o_out.ready;
    assign i_in.ready = en;

    spfpu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in.valid),
        .i_action (i_in.action),
        .i_a      (i_in.operand_a),
        .i_b      (i_in.operand_b),
        .o_valid  (front_valid),
        .o_pre    (front_pre),
        .o_div    (front_div)
    );

    spfpu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_div   (front_div),
        .i_valid (front_valid),
        .i_pre   (front_pre),
        .o_valid (div_valid),
        .o_pre   (div_pre)
    );

    spfpu_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid),
        .i_pre   (div_pre),
        .o_valid (out_valid),
        .o_bits  (o_out.result_bits),
        .o_order (out_order),
        .o_unord (o_out.unordered),
        .o_flag  (o_out.range_flag)
    );

    assign o_out.valid = out_valid;
    assign o_out.order = $signed(out_order);

endmodule
`default_nettype wire

// ----- hdl/spfpu_front.sv -----
// Front pipeline, stages 1 to 4: decode, align, multiply, normalize, conversions.
`default_nettype none
module spfpu_front
    import spfpu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [3:0]  i_action,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_valid,
    output t_pre        o_pre,
    output t_div        o_div
);

    typedef enum logic [2:0] {P_BYP, P_ADD, P_MUL, P_INT, P_F2I, P_DIV} t_path;

    // stage 1
    logic        za, zb, a_ge, nan_a, nan_b;
    logic [31:0] b_eff, x, y, mag;
    logic [7:0]  d;
    logic [26:0] my_full, my_al;
    logic [8:0]  unb;
    logic [86:0] wide;
    logic [30:0] am, bm;
    t_path       n_path;
    logic        n_sign;
    logic [63:0] n_bits;
    logic [1:0]  n_order;
    logic        n_unord;

    t_path       r_s1_path;
    logic        r_s1_valid, r_s1_sign, r_s1_sub, r_s1_unord;
    logic [3:0]  r_s1_op;
    logic [7:0]  r_s1_ex;
    logic [26:0] r_s1_mx, r_s1_my;
    logic [47:0] r_s1_prod;
    logic [10:0] r_s1_mexp;
    logic [31:0] r_s1_mag, r_s1_a;
    logic [8:0]  r_s1_unb;
    logic [63:0] r_s1_trunc, r_s1_bits;
    logic [1:0]  r_s1_order;
    t_div        r_s1_div;

    assign za    = (i_a[30:23] == 8'd0);
    assign zb    = (i_b[30:23] == 8'd0);
    assign b_eff = (i_action == OP_SUB) ? (i_b ^ SIGN_BIT) : i_b;
    assign a_ge  = ((i_a & ABS_MASK) >= (b_eff & ABS_MASK));
    assign x     = a_ge ? i_a : b_eff;
    assign y     = a_ge ? b_eff : i_a;
    assign d     = x[30:23] - y[30:23];
    assign my_full = {1'b1, y[22:0], 3'b000};
    assign my_al = (d >= 8'd27) ? 27'd1
                 : ((my_full >> d[4:0])
                    | {26'd0, |(my_full & ~({27{1'b1}} << d[4:0]))});
    assign mag   = (i_action == OP_S2F && i_a[31]) ? (32'd0 - i_a) : i_a;
    assign unb   = {1'b0, i_a[30:23]} - 9'(EXP_BIAS);
    assign wide  = {63'd0, 1'b1, i_a[22:0]} << unb[5:0];
    assign am    = za ? 31'd0 : i_a[30:0];
    assign bm    = zb ? 31'd0 : i_b[30:0];
    assign nan_a = ((i_a & EXP_MASK) == EXP_MASK) && ((i_a & MAN_MASK) != 32'd0);
    assign nan_b = ((i_b & EXP_MASK) == EXP_MASK) && ((i_b & MAN_MASK) != 32'd0);

    always_comb begin
        n_path  = P_BYP;
        n_sign  = 1'b0;
        n_bits  = 64'd0;
        n_order = ORD_EQ;
        n_unord = 1'b0;
        case (i_action)
            OP_ADD, OP_SUB: begin
                n_sign = x[31];
                if (za && zb) begin
                    n_bits = {32'd0, (i_a & b_eff) & SIGN_BIT};
                end else if (za) begin
                    n_bits = {32'd0, b_eff};
                end else if (zb) begin
                    n_bits = {32'd0, i_a};
                end else begin
                    n_path = P_ADD;
                end
            end
            OP_MUL: begin
                n_sign = i_a[31] ^ i_b[31];
                if (za || zb) begin
                    n_bits = {32'd0, n_sign, 31'd0};
                end else begin
                    n_path = P_MUL;
                end
            end
            OP_DIV: begin
                n_sign = i_a[31] ^ i_b[31];
                if (zb) begin
                    n_bits = {32'd0, n_sign, EXP_MASK[30:0]};
                end else if (za) begin
                    n_bits = {32'd0, n_sign, 31'd0};
                end else begin
                    n_path = P_DIV;
                end
            end
            OP_NEG: begin
                n_bits = {32'd0, i_a ^ SIGN_BIT};
            end
            OP_S2F, OP_U2F: begin
                n_sign = (i_action == OP_S2F) && i_a[31];
                if (mag != 32'd0) begin
                    n_path = P_INT;
                end
            end
            OP_F2S32, OP_F2U32, OP_F2S64: begin
                n_path = P_F2I;
            end
            OP_CMP: begin
                if (am == 31'd0 && bm == 31'd0) begin
                    n_order = ORD_EQ;
                end else if (i_a[31] != i_b[31]) begin
                    n_order = i_a[31] ? ORD_LT : ORD_GT;
                end else if (am == bm) begin
                    n_order = ORD_EQ;
                end else begin
                    n_order = ((am < bm) ^ i_a[31]) ? ORD_LT : ORD_GT;
                end
            end
            OP_UNORD: begin
                n_unord = nan_a || nan_b;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
        if (i_en) begin
            r_s1_path  <= n_path;
            r_s1_op    <= i_action;
            r_s1_sign  <= n_sign;
            r_s1_sub   <= x[31] ^ y[31];
            r_s1_ex    <= x[30:23];
            r_s1_mx    <= {1'b1, x[22:0], 3'b000};
            r_s1_my    <= my_al;
            r_s1_prod  <= {1'b1, i_a[22:0]} * {1'b1, i_b[22:0]};
            r_s1_mexp  <= {3'd0, i_a[30:23]} + {3'd0, i_b[30:23]} - (EXP_BIAS - 11'd1);
            r_s1_mag   <= mag;
            r_s1_a     <= i_a;
            r_s1_unb   <= unb;
            r_s1_trunc <= wide[86:23];
            r_s1_bits  <= n_bits;
            r_s1_order <= n_order;
            r_s1_unord <= n_unord;
            r_s1_div.sign <= n_sign;
            r_s1_div.expo <= {3'd0, i_a[30:23]} - {3'd0, i_b[30:23]} + EXP_BIAS;
            r_s1_div.mb   <= {1'b1, i_b[22:0]};
            r_s1_div.rem  <= {2'b01, i_a[22:0]};
            r_s1_div.quo  <= '0;
        end
    end

    assign o_div = r_s1_div;

    // stage 2
    logic [27:0]       sum28;
    logic [26:0]       dif;
    logic [47:0]       pn;
    logic signed [8:0] sunb;
    logic              za1, neg1;
    t_path             n2_path;
    logic [10:0]       n2_expo;
    logic [26:0]       n2_sig;
    logic [4:0]        n2_lz;
    logic [63:0]       n2_bits;
    logic              n2_flag;

    t_path       r_s2_path;
    logic        r_s2_valid, r_s2_sign, r_s2_unord, r_s2_flag;
    logic [10:0] r_s2_expo;
    logic [26:0] r_s2_sig;
    logic [31:0] r_s2_mag;
    logic [4:0]  r_s2_lz;
    logic [63:0] r_s2_bits;
    logic [1:0]  r_s2_order;

    assign sum28 = {1'b0, r_s1_mx} + {1'b0, r_s1_my};
    assign dif   = r_s1_mx - r_s1_my;
    assign pn    = r_s1_prod[47] ? r_s1_prod : {r_s1_prod[46:0], 1'b0};
    assign sunb  = $signed(r_s1_unb);
    assign za1   = (r_s1_a[30:23] == 8'd0);
    assign neg1  = r_s1_a[31];

    always_comb begin
        n2_path = r_s1_path;
        n2_expo = {3'd0, r_s1_ex};
        n2_sig  = '0;
        n2_lz   = '0;
        n2_bits = r_s1_bits;
        n2_flag = 1'b0;
        case (r_s1_path)
            P_ADD: begin
                if (!r_s1_sub) begin
                    if (sum28[27]) begin
                        n2_sig  = sum28[27:1] | {26'd0, sum28[0]};
                        n2_expo = {3'd0, r_s1_ex} + 11'd1;
                    end else begin
                        n2_sig = sum28[26:0];
                    end
                end else if (dif == 27'd0) begin
                    n2_path = P_BYP;
                    n2_bits = 64'd0;
                end else begin
                    n2_sig = dif;
                end
            end
            P_MUL: begin
                n2_sig  = {pn[47:22], pn[21] | (|pn[20:0])};
                n2_expo = r_s1_mexp - {10'd0, ~r_s1_prod[47]};
            end
            P_INT: begin
                n2_lz = lzc32(r_s1_mag);
            end
            P_F2I: begin
                n2_path = P_BYP;
                n2_bits = 64'd0;
                case (r_s1_op)
                    OP_F2S32: begin
                        if (za1 || sunb < 0) begin
                            n2_bits = 64'd0;
                        end else if (r_s1_a == F_INT32_LOW) begin
                            n2_bits = INT32_LOW;
                        end else if (sunb > 9'sd30) begin
                            n2_flag = 1'b1;
                            n2_bits = neg1 ? INT32_LOW : INT32_TOP;
                        end else begin
                            n2_bits = neg1 ? (64'd0 - r_s1_trunc) : r_s1_trunc;
                        end
                    end
                    OP_F2U32: begin
                        if (za1 || sunb < 0) begin
                            n2_bits = 64'd0;
                        end else if (neg1) begin
                            n2_flag = 1'b1;
                        end else if (sunb > 9'sd31) begin
                            n2_flag = 1'b1;
                            n2_bits = UINT32_TOP;
                        end else begin
                            n2_bits = r_s1_trunc;
                        end
                    end
                    OP_F2S64: begin
                        if (za1 || sunb < 0) begin
                            n2_bits = 64'd0;
                        end else if (r_s1_a == F_INT64_MIN) begin
                            n2_bits = INT64_MIN;
                        end else if (sunb > 9'sd62) begin
                            n2_flag = 1'b1;
                            n2_bits = neg1 ? INT64_MIN : INT64_TOP;
                        end else begin
                            n2_bits = neg1 ? (64'd0 - r_s1_trunc) : r_s1_trunc;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
        if (i_en) begin
            r_s2_path  <= n2_path;
            r_s2_sign  <= r_s1_sign;
            r_s2_expo  <= n2_expo;
            r_s2_sig   <= n2_sig;
            r_s2_mag   <= r_s1_mag;
            r_s2_lz    <= n2_lz;
            r_s2_bits  <= n2_bits;
            r_s2_order <= r_s1_order;
            r_s2_unord <= r_s1_unord;
            r_s2_flag  <= n2_flag;
        end
    end

    // stage 3
    logic [31:0] norm;
    logic [10:0] n3_expo;
    logic [26:0] n3_sig;
    logic [4:0]  n3_lz;

    t_path       r_s3_path;
    logic        r_s3_valid, r_s3_sign, r_s3_unord, r_s3_flag;
    logic [10:0] r_s3_expo;
    logic [26:0] r_s3_sig;
    logic [4:0]  r_s3_lz;
    logic [63:0] r_s3_bits;
    logic [1:0]  r_s3_order;

    assign norm = r_s2_mag << r_s2_lz;

    always_comb begin
        n3_expo = r_s2_expo;
        n3_sig  = r_s2_sig;
        n3_lz   = 5'd0;
        case (r_s2_path)
            P_ADD: begin
                n3_lz = lzc32({r_s2_sig, 5'd0});
            end
            P_INT: begin
                n3_sig  = {norm[31:6], norm[5] | (|norm[4:0])};
                n3_expo = (EXP_BIAS + 11'd31) - {6'd0, r_s2_lz};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= r_s2_valid;
        end
        if (i_en) begin
            r_s3_path  <= r_s2_path;
            r_s3_sign  <= r_s2_sign;
            r_s3_expo  <= n3_expo;
            r_s3_sig   <= n3_sig;
            r_s3_lz    <= n3_lz;
            r_s3_bits  <= r_s2_bits;
            r_s3_order <= r_s2_order;
            r_s3_unord <= r_s2_unord;
            r_s3_flag  <= r_s2_flag;
        end
    end

    // stage 4
    t_pre r_s4_pre;
    logic r_s4_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s4_valid <= r_s3_valid;
        end
        if (i_en) begin
            r_s4_pre.rnd    <= (r_s3_path != P_BYP);
            r_s4_pre.is_div <= (r_s3_path == P_DIV);
            r_s4_pre.sign   <= r_s3_sign;
            r_s4_pre.expo   <= r_s3_expo - {6'd0, r_s3_lz};
            r_s4_pre.sig    <= r_s3_sig << r_s3_lz;
            r_s4_pre.bits   <= r_s3_bits;
            r_s4_pre.order  <= r_s3_order;
            r_s4_pre.unord  <= r_s3_unord;
            r_s4_pre.flag   <= r_s3_flag;
        end
    end

    assign o_valid = r_s4_valid;
    assign o_pre   = r_s4_pre;

endmodule
`default_nettype wire

// ----- hdl/spfpu_div.sv -----
// Pipelined radix-4 restoring divider with the matching delay line for other words.
`default_nettype none
module spfpu_div
    import spfpu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_div i_div,
    input  logic i_valid,
    input  t_pre i_pre,
    output logic o_valid,
    output t_pre o_pre
);

    t_div               r_stage [DIV_STAGES];
    t_pre               r_dly   [PRE_DLY];
    logic [PRE_DLY-1:0] r_dly_valid;

    function automatic t_div div_step(input t_div d);
        t_div r;
        logic ge;
        r = d;
        for (int k = 0; k < DIV_BITS; k++) begin
            ge = (r.rem >= {1'b0, r.mb});
            if (ge) begin
                r.rem = r.rem - {1'b0, r.mb};
            end
            r.quo = {r.quo[QUO_W-2:0], ge};
            r.rem = {r.rem[23:0], 1'b0};
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly_valid <= '0;
        end else if (i_en) begin
            r_dly_valid <= {r_dly_valid[PRE_DLY-2:0], i_valid};
        end
        if (i_en) begin
            r_stage[0] <= div_step(i_div);
            for (int j = 1; j < DIV_STAGES; j++) begin
                r_stage[j] <= div_step(r_stage[j-1]);
            end
            r_dly[0] <= i_pre;
            for (int j = 1; j < PRE_DLY; j++) begin
                r_dly[j] <= r_dly[j-1];
            end
        end
    end

    t_div        fin;
    logic        st;
    logic [26:0] q27;
    logic [10:0] qexp;

    assign fin = r_stage[DIV_STAGES-1];

    always_comb begin
        st = (fin.rem != 25'd0);
        if (fin.quo[QUO_W-1]) begin
            q27  = fin.quo[QUO_W-1:1];
            st   = st | fin.quo[0];
            qexp = fin.expo;
        end else begin
            q27  = fin.quo[QUO_W-2:0];
            qexp = fin.expo - 11'd1;
        end
        o_pre = r_dly[PRE_DLY-1];
        if (o_pre.is_div) begin
            o_pre.sign = fin.sign;
            o_pre.expo = qexp;
            o_pre.sig  = q27 | {26'd0, st};
        end
    end

    assign o_valid = r_dly_valid[PRE_DLY-1];

endmodule
`default_nettype wire

// ----- hdl/spfpu_round.sv -----
// Final stage: round to nearest even, range check, pack; holds the output word.
`default_nettype none
module spfpu_round
    import spfpu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_pre        i_pre,
    output logic        o_valid,
    output logic [63:0] o_bits,
    output logic [1:0]  o_order,
    output logic        o_unord,
    output logic        o_flag
);

    logic [2:0]        low;
    logic              up;
    logic [24:0]       m2;
    logic [23:0]       mfin;
    logic [10:0]       e2;
    logic signed [10:0] se;
    logic [63:0]       n_bits;
    logic              n_flag;

    logic        r_valid, r_unord, r_flag;
    logic [63:0] r_bits;
    logic [1:0]  r_order;

    assign low  = i_pre.sig[2:0];
    assign up   = (low > 3'd4) || (low == 3'd4 && i_pre.sig[3]);
    assign m2   = {1'b0, i_pre.sig[26:3]} + {24'd0, up};
    assign mfin = m2[24] ? m2[24:1] : m2[23:0];
    assign e2   = i_pre.expo + {10'd0, m2[24]};
    assign se   = $signed(e2);

    always_comb begin
        n_bits = i_pre.bits;
        n_flag = i_pre.flag;
        if (i_pre.rnd) begin
            if (se >= 11'sd255) begin
                n_flag = 1'b1;
                n_bits = {32'd0, i_pre.sign, EXP_MASK[30:0]};
            end else if (se <= 11'sd0) begin
                n_flag = 1'b1;
                n_bits = {32'd0, i_pre.sign, 31'd0};
            end else begin
                n_flag = 1'b0;
                n_bits = {32'd0, i_pre.sign, e2[7:0], mfin[22:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_bits  <= n_bits;
            r_flag  <= n_flag;
            r_order <= i_pre.order;
            r_unord <= i_pre.unord;
        end
    end

    assign o_valid = r_valid;
    assign o_bits  = r_bits;
    assign o_order = r_order;
    assign o_unord = r_unord;
    assign o_flag  = r_flag;

endmodule
`default_nettype wire

// ----- tb/spfpu_checker.sv -----
// Checker for the single-precision FPU: watches both channels, predicts results and compares.
`timescale 1ns / 1ps
module spfpu_checker
    import spfpu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    spfpu_in_if         i_in,
    spfpu_out_if        i_out,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [63:0] bits;
        logic [1:0]  order;
        logic        unord;
        logic        flag;
    } t_fpu_res;

    t_fpu_res expected_results[$];

    function automatic logic fz(input logic [31:0] x);
        return x[30:23] == 8'd0;
    endfunction

    function automatic logic [31:0] sigv(input logic [31:0] x);
        return {8'd0, 1'b1, x[22:0]};
    endfunction

    function automatic logic [31:0] pack_rounded(input logic sign, input int e,
                                                 input logic [31:0] sig, inout logic flag);
        logic [2:0]  low;
        logic [31:0] m;
        low = sig[2:0];
        m = sig >> 3;
        if (low > 3'd4 || (low == 3'd4 && m[0])) begin
            m++;
            if (m == 32'h0100_0000) begin
                m = m >> 1;
                e++;
            end
        end
        if (e >= 255) begin
            flag = 1'b1;
            return {sign, 31'd0} | EXP_MASK;
        end
        if (e <= 0) begin
            flag = 1'b1;
            return {sign, 31'd0};
        end
        return {sign, 8'(e), m[22:0]};
    endfunction

    function automatic logic [31:0] float_sum(input logic [31:0] a, input logic [31:0] b,
                                              inout logic flag);
        logic [31:0] x, y, mx, my, s;
        int ex, ey, d;
        if (fz(a) && fz(b)) return (a & b) & SIGN_BIT;
        if (fz(a)) return b;
        if (fz(b)) return a;
        if ((a & ABS_MASK) >= (b & ABS_MASK)) begin
            x = a; y = b;
        end else begin
            x = b; y = a;
        end
        ex = x[30:23]; ey = y[30:23];
        mx = sigv(x) << 3; my = sigv(y) << 3;
        d = ex - ey;
        if (d >= 27) my = 32'd1;
        else if (d > 0) my = (my >> d) | 32'((my & ((32'd1 << d) - 1)) != 0);
        if (x[31] == y[31]) begin
            s = mx + my;
            if (s[27]) begin
                s = (s >> 1) | {31'd0, s[0]};
                ex++;
            end
        end else begin
            s = mx - my;
            if (s == 0) return 32'd0;
            while (!s[26]) begin
                s = s << 1;
                ex--;
            end
        end
        return pack_rounded(x[31], ex, s, flag);
    endfunction

    function automatic logic [31:0] float_product(input logic [31:0] a, input logic [31:0] b,
                                                  inout logic flag);
        logic        sign;
        logic [63:0] p;
        int          e;
        logic [31:0] sig;
        sign = a[31] ^ b[31];
        if (fz(a) || fz(b)) return {sign, 31'd0};
        p = 64'(sigv(a)) * 64'(sigv(b));
        e = int'(a[30:23]) + int'(b[30:23]) - 127 + 1;
        if (!p[47]) begin
            p = p << 1;
            e--;
        end
        sig = 32'(p >> 21) | 32'(p[20:0] != 0);
        return pack_rounded(sign, e, sig, flag);
    endfunction

    function automatic logic [31:0] float_quotient(input logic [31:0] a, input logic [31:0] b,
                                                   inout logic flag);
        logic        sign, st;
        logic [63:0] num, q, r, mb;
        int          e;
        sign = a[31] ^ b[31];
        if (fz(b)) return {sign, 31'd0} | EXP_MASK;
        if (fz(a)) return {sign, 31'd0};
        mb = 64'(sigv(b));
        num = 64'(sigv(a)) << 27;
        q = num / mb;
        r = num - q * mb;
        st = r != 0;
        if (q[27]) begin
            st = st | q[0];
            q = q >> 1;
            e = int'(a[30:23]) - int'(b[30:23]) + 127;
        end else begin
            e = int'(a[30:23]) - int'(b[30:23]) + 126;
        end
        return pack_rounded(sign, e, 32'(q) | 32'(st), flag);
    endfunction

    function automatic logic [31:0] int_to_float(input logic sign, input logic [31:0] mag,
                                                 inout logic flag);
        int          p, sh;
        logic [31:0] sig;
        if (mag == 0) return 32'd0;
        p = 31;
        while (!mag[p]) p--;
        if (p >= 26) begin
            sh = p - 26;
            sig = (mag >> sh) | 32'(sh > 0 && (mag & ((32'd1 << sh) - 1)) != 0);
        end else begin
            sig = mag << (26 - p);
        end
        return pack_rounded(sign, p + 127, sig, flag);
    endfunction

    function automatic logic [63:0] trunc_int(input logic [31:0] a, input int unb);
        logic [63:0] m;
        m = 64'(sigv(a));
        if (unb >= 23) return m << (unb - 23);
        return m >> (23 - unb);
    endfunction

    function automatic logic [1:0] order_of(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] am, bm;
        am = fz(a) ? 32'd0 : (a & ABS_MASK);
        bm = fz(b) ? 32'd0 : (b & ABS_MASK);
        if (am == 0 && bm == 0) return ORD_EQ;
        if (a[31] != b[31]) return a[31] ? ORD_LT : ORD_GT;
        if (am == bm) return ORD_EQ;
        return ((am < bm) ^ a[31]) ? ORD_LT : ORD_GT;
    endfunction

    function automatic logic is_nan(input logic [31:0] x);
        return (x & EXP_MASK) == EXP_MASK && (x & MAN_MASK) != 0;
    endfunction

    function automatic t_fpu_res fpu_predict(input logic [3:0] op, input logic [31:0] a,
                                             input logic [31:0] b);
        t_fpu_res    r;
        logic [31:0] f;
        logic [63:0] t;
        int          unb;
        r = '0;
        f = '0;
        unb = int'(a[30:23]) - 127;
        case (op)
            OP_ADD:   r.bits = 64'(float_sum(a, b, r.flag));
            OP_SUB:   r.bits = 64'(float_sum(a, b ^ SIGN_BIT, r.flag));
            OP_MUL:   r.bits = 64'(float_product(a, b, r.flag));
            OP_DIV:   r.bits = 64'(float_quotient(a, b, r.flag));
            OP_NEG:   r.bits = 64'(a ^ SIGN_BIT);
            OP_S2F:   r.bits = 64'(int_to_float(a[31], a[31] ? -a : a, r.flag));
            OP_U2F:   r.bits = 64'(int_to_float(1'b0, a, r.flag));
            OP_F2S32: begin
                if (fz(a) || unb < 0) r.bits = '0;
                else if (a == F_INT32_LOW) r.bits = INT32_LOW;
                else if (unb > 30) begin
                    r.flag = 1'b1;
                    r.bits = a[31] ? INT32_LOW : INT32_TOP;
                end else begin
                    t = trunc_int(a, unb);
                    r.bits = a[31] ? -t : t;
                end
            end
            OP_F2U32: begin
                if (fz(a) || unb < 0) r.bits = '0;
                else if (a[31]) r.flag = 1'b1;
                else if (unb > 31) begin
                    r.flag = 1'b1;
                    r.bits = UINT32_TOP;
                end else r.bits = trunc_int(a, unb);
            end
            OP_F2S64: begin
                if (fz(a) || unb < 0) r.bits = '0;
                else if (a == F_INT64_MIN) r.bits = INT64_MIN;
                else if (unb > 62) begin
                    r.flag = 1'b1;
                    r.bits = a[31] ? INT64_MIN : INT64_TOP;
                end else begin
                    t = trunc_int(a, unb);
                    r.bits = a[31] ? -t : t;
                end
            end
            OP_CMP:   r.order = order_of(a, b);
            OP_UNORD: r.unord = is_nan(a) || is_nan(b);
            default:  r = '0;
        endcase
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_fpu_res e;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                expected_results.push_back(fpu_predict(i_in.action, i_in.operand_a,
                                                       i_in.operand_b));
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, i_out.result_bits);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (e.bits !== i_out.result_bits || e.order !== i_out.order ||
                        e.unord !== i_out.unordered || e.flag !== i_out.range_flag) begin
                        $display("%0t: mismatch exp %h/%b/%b/%b got %h/%b/%b/%b", $time,
                                 e.bits, e.order, e.unord, e.flag, i_out.result_bits,
                                 i_out.order, i_out.unordered, i_out.range_flag);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/single_precision_fpu_core_tb.sv -----
// Testbench top: drives directed and random FPU words with random stalls, gives the verdict.
`timescale 1ns / 1ps
module single_precision_fpu_core_tb;
    import spfpu_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    logic hold_mode;
    logic pause_req;

    spfpu_in_if  in_ch();
    spfpu_out_if out_ch();

    single_precision_fpu_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    spfpu_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] rand_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0: v[30:23] = 8'd0;
            1: v[30:23] = 8'd255;
            2: v[30:23] = 8'(127 + $urandom_range(0, 66));
            3: v[30:23] = 8'($urandom_range(1, 8));
            4: v[30:23] = 8'($urandom_range(245, 254));
            default: v[30:23] = 8'($urandom_range(100, 154));
        endcase
        return v;
    endfunction

    task automatic send_word(input logic [3:0] op, input logic [31:0] a,
                             input logic [31:0] b);
        in_ch.valid     <= 1'b1;
        in_ch.action    <= op;
        in_ch.operand_a <= a;
        in_ch.operand_b <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_gap();
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // receiver stalls
    initial begin
        int g;
        out_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_mode) begin
                out_ch.ready <= 1'b0;
                repeat (80) @(posedge i_clk);
                hold_mode = 1'b0;
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            g = gap_len();
            if (g > 0) begin
                out_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    // watchdog
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !pause_req)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 2000) begin
                $display("single_precision_fpu_core test failed");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] a, b;
        logic [3:0]  op;
        hold_mode = 1'b0;
        pause_req = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.action    <= OP_ADD;
        in_ch.operand_a <= '0;
        in_ch.operand_b <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        pause_req = 1'b1;
        send_word(OP_ADD, 32'h3FC0_0000, 32'h4020_0000);
        send_word(OP_ADD, 32'h8000_0000, 32'h8000_0001);
        send_word(OP_SUB, 32'h3F80_0000, 32'h3F80_0000);
        send_word(OP_SUB, 32'h0000_0000, 32'h4000_0000);
        send_word(OP_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
        send_word(OP_SUB, 32'h0080_0001, 32'h0080_0000);
        send_word(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(OP_MUL, 32'h0080_0000, 32'h0080_0000);
        send_word(OP_MUL, 32'h7F80_0000, 32'h3F80_0000);
        send_word(OP_DIV, 32'h0000_0000, 32'h8000_0000);
        send_word(OP_DIV, 32'hBF80_0000, 32'h0000_0000);
        send_word(OP_DIV, 32'h3F80_0000, 32'h4040_0000);
        send_word(OP_NEG, 32'h0000_0001, 32'hFFFF_FFFF);
        send_word(OP_S2F, 32'h8000_0000, 32'h0);
        send_word(OP_S2F, 32'h7FFF_FFFF, 32'h0);
        send_word(OP_U2F, 32'hFFFF_FFFF, 32'h0);
        send_word(OP_F2S32, F_INT32_LOW, 32'h0);
        send_word(OP_F2S32, 32'h4F00_0000, 32'h0);
        send_word(OP_F2U32, 32'hBF80_0000, 32'h0);
        send_word(OP_F2U32, 32'h4F80_0000, 32'h0);
        send_word(OP_F2S64, F_INT64_MIN, 32'h0);
        send_word(OP_F2S64, 32'h3F7F_FFFF, 32'h0);
        send_word(OP_CMP, 32'h8000_0000, 32'h0000_0000);
        send_word(OP_UNORD, 32'h3F80_0000, 32'h7FC0_0000);
        send_word(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 450; i++) begin
            if (i == 150) hold_mode = 1'b1;
            if (i == 300) begin
                in_ch.valid <= 1'b0;
                while (pending != 0) @(posedge i_clk);
            end
            op = 4'($urandom_range(0, 12) == 12 ? $urandom_range(12, 15) : $urandom_range(0, 11));
            a = (op == OP_S2F || op == OP_U2F) ? $urandom >> $urandom_range(0, 31)
                                               : rand_float();
            if (op == OP_S2F && $urandom_range(0, 1)) a = -a;
            b = rand_float();
            if ($urandom_range(0, 9) == 0) b = a ^ ($urandom_range(0, 1) ? SIGN_BIT : 32'd0);
            send_word(op, a, b);
            if (i % 40 > 25) send_gap();
        end
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("single_precision_fpu_core test passed");
        else
            $display("single_precision_fpu_core test failed");
        $finish;
    end

endmodule
